@@ rtl/row_by_row_maze_walls_top_macros.svh @@
// Assertion macros for the maze row generator.
`ifndef ROW_BY_ROW_MAZE_WALLS_TOP_MACROS_SVH
`define ROW_BY_ROW_MAZE_WALLS_TOP_MACROS_SVH
`ifndef SYNTH
// check outside reset
`define MZW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// check on every edge, reset included
`define MZW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define MZW_ASSERT(lbl, prop, msg)
`define MZW_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/mzw_pkg.sv @@
// Shared types and constants of the maze row generator.
`default_nettype none
package mzw_pkg;

  localparam int MAX_COLUMNS_DEF = 32;
  localparam int LABEL_BITS_DEF  = 16;

  localparam int JOIN_W = 31;
  localparam int DOWN_W = 32;
  localparam int CFG_W  = 6;

  localparam logic [CFG_W-1:0] COLUMNS_RESET = 6'd32;
  localparam logic             REG_COLUMNS   = 1'b0;

  typedef enum logic [1:0] {
    MODE_FIRST  = 2'd0,
    MODE_ONLY   = 2'd1,
    MODE_MIDDLE = 2'd2,
    MODE_LAST   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_MERGE,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic shift;
    logic merge;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ rtl/mzw_cell.sv @@
// One column cell of the rotating label ring.
`default_nettype none
module mzw_cell import mzw_pkg::*; #(
  parameter int LB      = LABEL_BITS_DEF,
  parameter int CW      = 5,
  parameter int WW      = 6,
  parameter int TAG_RST = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctl_t     ctl_i,
  input  logic [LB-1:0] gone_i,
  input  logic [LB-1:0] keep_i,
  input  logic [WW-1:0] w_i,
  input  logic [LB-1:0] lab_in_i,
  input  logic [CW-1:0] tag_in_i,
  output logic [LB-1:0] lab_o,
  output logic [CW-1:0] tag_o
);

  logic [LB-1:0] lab_q, lab_d;
  logic [CW-1:0] tag_q;
  logic          hit;

  // relabel the incoming word when it carries the label being merged away
  assign hit   = ctl_i.merge && (WW'(tag_in_i) < w_i) && (lab_in_i == gone_i);
  assign lab_d = hit ? keep_i : lab_in_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= CW'(TAG_RST);
    end else if (ctl_i.shift) begin
      tag_q <= tag_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      lab_q <= lab_d;
    end
  end

  assign lab_o = lab_q;
  assign tag_o = tag_q;

endmodule
`default_nettype wire

@@ rtl/mzw_ctrl.sv @@
// Row sequencer: steps the ring, decides walls, hands out labels, holds the result.
`default_nettype none
module mzw_ctrl import mzw_pkg::*; #(
  parameter int N  = MAX_COLUMNS_DEF,
  parameter int LB = LABEL_BITS_DEF,
  parameter int CW = 5,
  parameter int WW = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [JOIN_W-1:0] join_bits_i,
  input  logic [DOWN_W-1:0] down_bits_i,
  input  logic [CFG_W-1:0]  cols_i,
  input  logic [LB-1:0]     lab0_i,
  input  logic [LB-1:0]     lab1_i,
  output logic [LB-1:0]     wb_o,
  output cell_ctl_t         ctl_o,
  output logic [LB-1:0]     gone_o,
  output logic [LB-1:0]     keep_o,
  output logic [WW-1:0]     w_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [JOIN_W-1:0] side_walls_o,
  output logic [DOWN_W-1:0] floor_walls_o,
  output logic              has_floor_o
);

  localparam int VW = (N > DOWN_W) ? N : DOWN_W;
  localparam int XW = $clog2(VW);
  localparam logic [CFG_W:0] NX = (CFG_W + 1)'(N);

  state_e        state_q, state_d;
  logic [CW-1:0] k_q, k_d;
  mode_e         mode_q;
  logic [VW-1:0] join_q, down_q;
  logic [VW-1:0] side_q, side_d, floor_q, floor_d;
  logic [LB-1:0] next_q, next_d, prev_q, prev_d;
  logic          accept, k_last, in_row, pair_ok, wall, copy, do_merge, fresh_row;
  logic          out_valid_q, out_load;
  logic [JOIN_W-1:0] out_side_q;
  logic [DOWN_W-1:0] out_floor_q;
  logic              out_floor_en_q;
  logic [XW-1:0]     kx, kx_m1;
  logic [WW-1:0]     kw;
  logic [CFG_W:0]    cols_x, w_x;

  // clamp the column count to 1..N
  assign cols_x = {1'b0, cols_i};
  always_comb begin
    if (cols_x == '0) begin
      w_x = (CFG_W + 1)'(1);
    end else if (cols_x > NX) begin
      w_x = NX;
    end else begin
      w_x = cols_x;
    end
  end
  assign w_o = WW'(w_x);

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign k_last    = (k_q == CW'(N - 1));
  assign kx        = XW'(k_q);
  assign kx_m1     = kx - XW'(1);
  assign kw        = WW'(k_q);
  assign in_row    = kw < w_o;
  assign pair_ok   = (kw + WW'(1)) < w_o;
  assign fresh_row = (mode_q == MODE_FIRST) || (mode_q == MODE_ONLY);
  assign out_load  = (state_q == ST_FLUSH) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_FILL;
      end
      ST_FILL: begin
        if (k_last) state_d = fresh_row ? ST_FLUSH : ST_MERGE;
      end
      ST_MERGE: begin
        if (k_last) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and ring control
  always_comb begin
    k_d      = k_q;
    side_d   = side_q;
    floor_d  = floor_q;
    next_d   = next_q;
    prev_d   = prev_q;
    wb_o     = lab0_i;
    gone_o   = lab1_i;
    keep_o   = lab0_i;
    ctl_o    = '0;
    wall     = 1'b0;
    copy     = 1'b0;
    do_merge = 1'b0;
    case (state_q)
      ST_FILL: begin
        ctl_o.shift = 1'b1;
        k_d = k_last ? '0 : k_q + CW'(1);
        if (fresh_row) begin
          if (in_row) begin
            copy = (mode_q == MODE_FIRST) && (k_q != '0) && !join_q[kx_m1];
            wb_o = copy ? prev_q : next_q;
            prev_d = wb_o;
            next_d = next_q + LB'(1);
            if ((mode_q == MODE_FIRST) && (k_q != '0)) begin
              side_d[kx_m1] = join_q[kx_m1];
            end
          end
        end else begin
          // keep the wall only inside a run that continues to the right
          wall = down_q[kx] && pair_ok && (lab0_i == lab1_i);
          if (wall) begin
            wb_o   = next_q;
            next_d = next_q + LB'(1);
          end
          floor_d[kx] = wall;
        end
      end
      ST_MERGE: begin
        ctl_o.shift = 1'b1;
        k_d = k_last ? '0 : k_q + CW'(1);
        do_merge = pair_ok && (lab0_i != lab1_i) &&
                   ((mode_q == MODE_LAST) || !join_q[kx]);
        ctl_o.merge = do_merge;
        side_d[kx] = pair_ok && !do_merge;
      end
      default: begin
        k_d = k_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      next_q      <= LB'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      next_q  <= next_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    if (accept) begin
      mode_q  <= mode_e'(mode_i);
      join_q  <= VW'(join_bits_i);
      down_q  <= VW'(down_bits_i);
      side_q  <= '0;
      floor_q <= '0;
    end else begin
      side_q  <= side_d;
      floor_q <= floor_d;
    end
    if (out_load) begin
      out_side_q     <= side_q[JOIN_W-1:0];
      out_floor_q    <= floor_q[DOWN_W-1:0];
      out_floor_en_q <= !fresh_row;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign side_walls_o  = out_side_q;
  assign floor_walls_o = out_floor_q;
  assign has_floor_o   = out_floor_en_q;

endmodule
`default_nettype wire

@@ rtl/row_by_row_maze_walls_top.sv @@
// Top level of the row-by-row maze wall generator.
//
// Each input word builds one maze row from random join and floor bits and returns
// the side walls, the floor walls and a flag for whether the floor applies. The set
// labels of the columns live in a ring of MAX_COLUMNS cells that, while a row is in
// work, rotates one place a cycle, so the current column and its right neighbor always
// sit in the first two cells; a merge relabels every matching cell in the same cycle.
// A first row or a single row takes one full turn of the ring, a middle or last row
// two turns (floor decisions, then merges), whatever the column count register holds.
// A finished row waits in an output register while the next word is taken. Labels
// are not cleared at reset: rows before the first first-row word are undefined.
// The column count register sits at byte address 0 and should be written while idle.
`default_nettype none
`include "row_by_row_maze_walls_top_macros.svh"
module row_by_row_maze_walls_top import mzw_pkg::*; #(
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int LABEL_BITS  = LABEL_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic [JOIN_W-1:0] join_bits_i,
  input  logic [DOWN_W-1:0] down_bits_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [JOIN_W-1:0] side_walls_o,
  output logic [DOWN_W-1:0] floor_walls_o,
  output logic              has_floor_o
);

  localparam int N  = MAX_COLUMNS;
  localparam int LB = LABEL_BITS;
  localparam int CW = (N > 1) ? $clog2(N) : 1;
  localparam int WW = $clog2(N + 1);
  localparam int NB = (N > 1) ? 1 : 0;

  logic [CFG_W-1:0] cols_q;
  logic [LB-1:0]    lab_w [N];
  logic [CW-1:0]    tag_w [N];
  logic [LB-1:0]    wb, gone, keep;
  logic [WW-1:0]    w;
  cell_ctl_t        ctl;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_COLUMNS) ? {{(32 - CFG_W){1'b0}}, cols_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLUMNS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_COLUMNS)) begin
      cols_q <= pwdata[CFG_W-1:0];
    end
  end

  mzw_ctrl #(.N(N), .LB(LB), .CW(CW), .WW(WW)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .join_bits_i   (join_bits_i),
    .down_bits_i   (down_bits_i),
    .cols_i        (cols_q),
    .lab0_i        (lab_w[0]),
    .lab1_i        (lab_w[NB]),
    .wb_o          (wb),
    .ctl_o         (ctl),
    .gone_o        (gone),
    .keep_o        (keep),
    .w_o           (w),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .side_walls_o  (side_walls_o),
    .floor_walls_o (floor_walls_o),
    .has_floor_o   (has_floor_o)
  );

  // ring: each cell takes its right neighbor, the last one takes the updated head
  for (genvar c = 0; c < N; c++) begin : g_cell
    if (c == N - 1) begin : g_tail
      mzw_cell #(.LB(LB), .CW(CW), .WW(WW), .TAG_RST(c)) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .gone_i   (gone),
        .keep_i   (keep),
        .w_i      (w),
        .lab_in_i (wb),
        .tag_in_i (tag_w[0]),
        .lab_o    (lab_w[c]),
        .tag_o    (tag_w[c])
      );
    end else begin : g_body
      mzw_cell #(.LB(LB), .CW(CW), .WW(WW), .TAG_RST(c)) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .gone_i   (gone),
        .keep_i   (keep),
        .w_i      (w),
        .lab_in_i (lab_w[c+1]),
        .tag_in_i (tag_w[c+1]),
        .lab_o    (lab_w[c]),
        .tag_o    (tag_w[c])
      );
    end
  end

  `MZW_ASSERT(a_accept_busy, in_valid_i && !in_stall_o |=> in_stall_o, "accepted word did not start a row")
  `MZW_ASSERT(a_ring_aligned, !in_stall_o |-> (tag_w[0] == '0), "label ring out of step while idle")
  `MZW_ASSERT(a_load_from_flush, $rose(out_valid_o) |-> $past(in_stall_o), "result appeared without a row in work")
  `MZW_ASSERT_ALWAYS(a_floor_flag, out_valid_o && !has_floor_o |-> (floor_walls_o == '0), "floor walls set on a row without floor")

endmodule
`default_nettype wire
